FILE: src/nsc_pkg.sv
// Shared types and character constants for the NMEA sentence checker.
`default_nettype none
package nsc_pkg;

    localparam int MAX_LINE_DEF = 128;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CASE_MASK  = 8'hDF;
    localparam logic [7:0] HEX_TEN    = 8'd10;

    localparam int RESULT_W = 26;
    localparam int M_TDATA_W = 32;

    // Packed from checksum_ok (MSB) down to line_length (LSB)
    typedef struct packed {
        logic       checksum_ok;
        logic       star_present;
        logic [7:0] received_sum;
        logic [7:0] computed_sum;
        logic [7:0] line_length;
    } nsc_result_t;

    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c > CH_NINE) begin
            v = (c & CASE_MASK) + HEX_TEN - CH_UPPER_A;
        end else begin
            v = c - CH_ZERO;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: src/nsc_line_tracker.sv
// Per-line state: length count, running XOR, star and checksum digit decode.
`default_nettype none
module nsc_line_tracker
    import nsc_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        fire,
    input  wire logic [7:0]  rx_byte,
    output logic             result_valid,
    output nsc_result_t      result
);

    localparam logic [7:0] MAX_COUNT = 8'(MAX_LINE);

    logic       in_line_reg,    in_line_next;
    logic [7:0] count_reg,      count_next;
    logic [7:0] xor_reg,        xor_next;
    logic       star_reg,       star_next;
    logic [1:0] digits_reg,     digits_next;
    logic [7:0] sum_reg,        sum_next;
    logic [7:0] digit_val;

    assign digit_val = hex_value(rx_byte);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_line_reg <= 1'b0;
            count_reg   <= '0;
            xor_reg     <= '0;
            star_reg    <= 1'b0;
            digits_reg  <= '0;
            sum_reg     <= '0;
        end else begin
            in_line_reg <= in_line_next;
            count_reg   <= count_next;
            xor_reg     <= xor_next;
            star_reg    <= star_next;
            digits_reg  <= digits_next;
            sum_reg     <= sum_next;
        end
    end

    always_comb begin
        in_line_next = in_line_reg;
        count_next   = count_reg;
        xor_next     = xor_reg;
        star_next    = star_reg;
        digits_next  = digits_reg;
        sum_next     = sum_reg;
        result_valid = 1'b0;

        result.line_length  = count_reg;
        result.computed_sum = xor_reg;
        result.received_sum = star_reg ? sum_reg : 8'h00;
        result.star_present = star_reg;
        result.checksum_ok  = star_reg && (digits_reg == 2'd2) && (sum_reg == xor_reg);

        if (fire) begin
            if (!in_line_reg) begin
                if (rx_byte == CH_DOLLAR) begin
                    in_line_next = 1'b1;
                    count_next   = 8'd1;
                    xor_next     = '0;
                    star_next    = 1'b0;
                    digits_next  = '0;
                    sum_next     = '0;
                end
            end else if (rx_byte == CH_LF || count_reg >= MAX_COUNT) begin
                // end of line emits; overlong line drops silently
                if (rx_byte == CH_LF) begin
                    result_valid = 1'b1;
                end
                if (rx_byte == CH_LF || rx_byte != CH_CR) begin
                    in_line_next = 1'b0;
                    count_next   = '0;
                    xor_next     = '0;
                    star_next    = 1'b0;
                    digits_next  = '0;
                    sum_next     = '0;
                end
            end else if (rx_byte != CH_CR) begin
                count_next = count_reg + 8'd1;
                if (!star_reg) begin
                    if (rx_byte == CH_STAR) begin
                        star_next = 1'b1;
                    end else begin
                        xor_next = xor_reg ^ rx_byte;
                    end
                end else if (digits_reg == 2'd0) begin
                    sum_next    = {digit_val[3:0], 4'h0};
                    digits_next = 2'd1;
                end else if (digits_reg == 2'd1) begin
                    sum_next    = sum_reg | digit_val;
                    digits_next = 2'd2;
                end
            end
        end
    end

    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_line_reg |-> (count_reg == 8'd0 && !star_reg && digits_reg == 2'd0))
        else $error("idle with stale line state");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        in_line_reg |-> (count_reg != 8'd0 && count_reg <= MAX_COUNT))
        else $error("line count out of range");

    a_emit_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        result_valid |=> !in_line_reg)
        else $error("line still open after result");

    a_digits_need_star: assert property (@(posedge aclk) disable iff (!aresetn)
        (digits_reg != 2'd0) |-> star_reg)
        else $error("checksum digits without star");

endmodule
`default_nettype wire

FILE: src/nmea_sentence_checker.sv
// Top level: input byte register, line tracker and result output register.
//
// channel | dir | fields (tdata, lowest bit up)
// s_      | in  | rx_byte[7:0]
// m_      | out | line_length[7:0], computed_sum[15:8], received_sum[23:16],
//         |     | star_present[24], checksum_ok[25], zero[31:26]
//
// One byte is taken per cycle unless a stalled result backs up into the input register;
// the LF byte is held in the input byte register and its result in the result register.
// aresetn is synchronous; it returns the tracker to waiting for '$' and empties both
// registers. A stalled result holds the pipe only when the input register is full.
`default_nettype none
module nmea_sentence_checker
    import nsc_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // rx_byte
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata    // line_length, computed_sum,
                                                 // received_sum, star_present,
                                                 // checksum_ok, zero pad
);

    logic        byte_valid_reg;
    logic [7:0]  byte_reg;
    logic        out_valid_reg;
    nsc_result_t out_reg;
    logic        advance;
    logic        res_valid;
    nsc_result_t res;

    // advance the held byte when the output slot is free or draining
    assign advance  = byte_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !byte_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_valid_reg <= 1'b0;
        end else if (s_tready) begin
            byte_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

    nsc_line_tracker #(
        .MAX_LINE(MAX_LINE)
    ) u_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (advance),
        .rx_byte     (byte_reg),
        .result_valid(res_valid),
        .result      (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - RESULT_W){1'b0}}, out_reg};

    a_ok_needs_star: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!out_reg.checksum_ok || out_reg.star_present))
        else $error("checksum_ok without star");

    a_no_star_zero_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !out_reg.star_present) |-> (out_reg.received_sum == 8'h00))
        else $error("received_sum set without star");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (!out_valid_reg || m_tready))
        else $error("result overwrote pending transfer");

endmodule
`default_nettype wire

FILE: tb/sv/nmea_sentence_checker_tb.sv
// Testbench for the NMEA sentence checker: random sentence stream with a self-checking scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module nmea_sentence_checker_tb;
    import nsc_pkg::*;

    localparam int         LINE_ITEMS     = 900;
    localparam int         HOLD_START     = 300;
    localparam int         DRAIN_START    = 550;
    localparam int         QUIET_START    = 750;
    localparam int         HOLD_CYCLES    = 200;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         SETTLE_CYCLES  = 16;
    localparam logic [7:0] CH_LOWER_A     = 8'h61;

    typedef enum int {
        LINE_GOOD,
        LINE_BAD_SUM,
        LINE_NO_STAR,
        LINE_SHORT_SUM,
        LINE_EXTRA,
        LINE_ODD_DIGITS,
        LINE_LONG,
        LINE_NOISE
    } line_kind_e;

    // Tracks the line state byte by byte and holds the results still owed by the block.
    class nmea_line_scoreboard;
        bit          in_line;
        logic [7:0]  char_count;
        logic [7:0]  running_xor;
        bit          star_seen;
        logic [1:0]  digits_after_star;
        logic [7:0]  sum_digits;
        nsc_result_t expected_q[$];
        int          errors;
        int          results_seen;
        int          good_lines;
        int          dropped_lines;

        function void clear_line();
            in_line           = 1'b0;
            char_count        = '0;
            running_xor       = '0;
            star_seen         = 1'b0;
            digits_after_star = '0;
            sum_digits        = '0;
        endfunction

        // Letters fold to upper case; anything else decodes by the same offset rule.
        function logic [7:0] nibble_of(logic [7:0] c);
            if (c > CH_NINE) begin
                return (c & CASE_MASK) - CH_UPPER_A + HEX_TEN;
            end
            return c - CH_ZERO;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_byte(logic [7:0] c);
            nsc_result_t res;
            if (!in_line) begin
                if (c == CH_DOLLAR) begin
                    clear_line();
                    in_line    = 1'b1;
                    char_count = 8'd1;
                end
                return;
            end
            if (c == CH_LF) begin
                res.line_length  = char_count;
                res.computed_sum = running_xor;
                res.received_sum = star_seen ? sum_digits : 8'h00;
                res.star_present = star_seen;
                res.checksum_ok  = star_seen && digits_after_star >= 2'd2 &&
                                   sum_digits == running_xor;
                expected_q.push_back(res);
                clear_line();
                return;
            end
            if (c == CH_CR) begin
                return;
            end
            // drop a line that would grow past the limit
            if (int'(char_count) >= MAX_LINE_DEF) begin
                dropped_lines++;
                clear_line();
                return;
            end
            char_count++;
            if (!star_seen) begin
                if (c == CH_STAR) begin
                    star_seen = 1'b1;
                end else begin
                    running_xor ^= c;
                end
            end else if (digits_after_star == 2'd0) begin
                sum_digits        = nibble_of(c) << 4;
                digits_after_star = 2'd1;
            end else if (digits_after_star == 2'd1) begin
                sum_digits        = sum_digits | nibble_of(c);
                digits_after_star = 2'd2;
            end
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] word);
            nsc_result_t got;
            nsc_result_t want;
            got = word[RESULT_W-1:0];
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, word);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            results_seen++;
            if (want.checksum_ok) begin
                good_lines++;
            end
            compare_field("line_length", want.line_length, got.line_length);
            compare_field("computed_sum", want.computed_sum, got.computed_sum);
            compare_field("received_sum", want.received_sum, got.received_sum);
            compare_field("star_present", 8'(want.star_present), 8'(got.star_present));
            compare_field("checksum_ok", 8'(want.checksum_ok), 8'(got.checksum_ok));
            compare_field("pad", 8'h00, 8'(word[M_TDATA_W-1:RESULT_W]));
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [7:0]           s_tdata  = 8'h00;
    logic                 m_tready = 1'b0;
    wire logic            s_tready;
    wire logic            m_tvalid;
    wire logic [M_TDATA_W-1:0] m_tdata;

    nmea_line_scoreboard sb = new();
    logic [7:0]          tx_q[$];
    int                  line_bytes  = 0;
    int                  noise_bytes = 0;
    bit                  hold_req    = 1'b0;
    bit                  quiet       = 1'b0;

    nmea_sentence_checker i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_byte(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
        end
    end

    // Result side: random stalls, one long hold-off on request, always ready at the end.
    initial begin
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    initial begin
        int stalled;
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        if (!quiet && !hold_req && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic flush_bytes(input bit counted);
        if (counted) begin
            line_bytes += tx_q.size();
        end else begin
            noise_bytes += tx_q.size();
        end
        while (tx_q.size() != 0) begin
            send_byte(tx_q.pop_front());
        end
    endtask

    function automatic logic [7:0] rand_payload(bit printable);
        logic [7:0] c;
        do begin
            c = printable ? 8'($urandom_range(8'h20, 8'h7E)) : 8'($urandom_range(0, 255));
        end while (c == CH_STAR || c == CH_LF || c == CH_CR);
        return c;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) begin
            return CH_ZERO + 8'(n);
        end
        return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 8'(n) - HEX_TEN;
    endfunction

    function automatic void push_sum(logic [7:0] value);
        tx_q.push_back(hex_char(value[7:4]));
        tx_q.push_back(hex_char(value[3:0]));
    endfunction

    // Queue one line; body_len below zero picks a random length for the kind.
    function automatic void build_line(line_kind_e kind, int body_len);
        logic [7:0] sum;
        logic [7:0] c;
        bit         printable;
        sum       = 8'h00;
        printable = (kind == LINE_LONG) || ($urandom_range(0, 3) != 0);
        if (kind == LINE_NOISE) begin
            repeat ($urandom_range(1, 6)) begin
                do c = 8'($urandom_range(0, 255)); while (c == CH_DOLLAR);
                tx_q.push_back(c);
            end
            return;
        end
        if (body_len < 0) begin
            body_len = (kind == LINE_LONG) ? $urandom_range(MAX_LINE_DEF - 8, MAX_LINE_DEF + 4)
                                           : $urandom_range(0, 24);
        end
        tx_q.push_back(CH_DOLLAR);
        repeat (body_len) begin
            c = rand_payload(printable);
            tx_q.push_back(c);
            sum ^= c;
            if (kind != LINE_LONG && $urandom_range(0, 15) == 0) begin
                tx_q.push_back(CH_CR);
            end
        end
        case (kind)
            LINE_GOOD, LINE_LONG: begin
                tx_q.push_back(CH_STAR);
                push_sum(sum);
            end
            LINE_BAD_SUM: begin
                tx_q.push_back(CH_STAR);
                push_sum(sum ^ 8'($urandom_range(1, 255)));
            end
            LINE_NO_STAR: begin
            end
            LINE_SHORT_SUM: begin
                tx_q.push_back(CH_STAR);
                if ($urandom_range(0, 1)) begin
                    tx_q.push_back(hex_char(sum[7:4]));
                end
            end
            LINE_EXTRA: begin
                tx_q.push_back(CH_STAR);
                push_sum(($urandom_range(0, 1)) ? sum : 8'($urandom_range(0, 255)));
                repeat ($urandom_range(1, 5)) begin
                    tx_q.push_back(($urandom_range(0, 2) == 0) ? CH_STAR : rand_payload(1'b0));
                end
            end
            default: begin
                // arbitrary bytes where the digits belong, with a CR between them now and then
                tx_q.push_back(CH_STAR);
                tx_q.push_back(rand_payload(1'b0));
                if ($urandom_range(0, 3) == 0) begin
                    tx_q.push_back(CH_CR);
                end
                tx_q.push_back(rand_payload(1'b0));
            end
        endcase
        if ($urandom_range(0, 1)) begin
            tx_q.push_back(CH_CR);
        end
        tx_q.push_back(CH_LF);
    endfunction

    initial begin
        int         pick;
        line_kind_e kind;
        bit         hold_done;
        bit         drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;

        aresetn <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // bytes ignored while idle, including LF and CR
        tx_q = '{8'h00, 8'hFF, CH_LF, CH_CR};
        flush_bytes(1'b0);
        // "$A*41" CR LF: matching sum
        tx_q = '{CH_DOLLAR, 8'h41, CH_STAR, 8'h34, 8'h31, CH_CR, CH_LF};
        flush_bytes(1'b1);
        // "$*": star with no digits
        tx_q = '{CH_DOLLAR, CH_STAR, CH_LF};
        flush_bytes(1'b1);
        // "$B*4": a single digit after the star
        tx_q = '{CH_DOLLAR, 8'h42, CH_STAR, 8'h34, CH_LF};
        flush_bytes(1'b1);
        // no star, top byte value in the body
        tx_q = '{CH_DOLLAR, 8'hFF, CH_LF};
        flush_bytes(1'b1);
        // "$j*6a": lower-case hex digit
        tx_q = '{CH_DOLLAR, 8'h6A, CH_STAR, 8'h36, CH_LOWER_A, CH_LF};
        flush_bytes(1'b1);

        // longest line that is kept, then one byte past the limit
        build_line(LINE_LONG, MAX_LINE_DEF - 4);
        flush_bytes(1'b1);
        build_line(LINE_LONG, MAX_LINE_DEF - 3);
        flush_bytes(1'b1);

        while (line_bytes < LINE_ITEMS) begin
            if (!hold_done && line_bytes >= HOLD_START) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            if (!drain_done && line_bytes >= DRAIN_START) begin
                drain_done = 1'b1;
                s_tvalid  <= 1'b0;
                do @(posedge aclk); while (sb.pending() != 0);
            end
            if (line_bytes >= QUIET_START) begin
                quiet = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 50)      kind = LINE_GOOD;
            else if (pick < 60) kind = LINE_BAD_SUM;
            else if (pick < 66) kind = LINE_NO_STAR;
            else if (pick < 73) kind = LINE_SHORT_SUM;
            else if (pick < 80) kind = LINE_EXTRA;
            else if (pick < 87) kind = LINE_ODD_DIGITS;
            else if (pick < 89) kind = LINE_LONG;
            else                kind = LINE_NOISE;
            build_line(kind, -1);
            flush_bytes(kind != LINE_NOISE);
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d line bytes and %0d idle noise bytes; %0d overlong lines dropped.",
                 line_bytes, noise_bytes, sb.dropped_lines);
        $display("Checked %0d sentence results, %0d of them with a matching checksum.",
                 sb.results_seen, sb.good_lines);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
src/nsc_pkg.sv
src/nsc_line_tracker.sv
src/nmea_sentence_checker.sv
tb/sv/nmea_sentence_checker_tb.sv
